/* rtl/core/clsd_pkg.sv */
// shared types and constants of the class-data record parser
package clsd_pkg;

    // section codes of the record walk
    localparam logic [2:0] SEC_HEADER   = 3'd0;
    localparam logic [2:0] SEC_STATIC   = 3'd1;
    localparam logic [2:0] SEC_INSTANCE = 3'd2;
    localparam logic [2:0] SEC_DIRECT   = 3'd3;
    localparam logic [2:0] SEC_VIRTUAL  = 3'd4;

    // result kinds
    localparam logic KIND_FIELD   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // leb128 limits
    localparam logic [2:0] LEB_LAST_POS  = 3'd4;
    localparam logic [7:0] LEB_CONT_MASK = 8'h80;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic  kind;
        t_word field_index;
        t_word access_flags;
        logic  last_field;
        t_word static_count;
        t_word instance_count;
        t_word direct_count;
        t_word virtual_count;
    } t_result;

    // results of one decoded byte: field first, then summary
    typedef struct packed {
        logic    field_valid;
        logic    sum_valid;
        t_result field;
        t_result summary;
    } t_push;

endpackage

/* rtl/core/clsd_parser.sv */
// byte input register and single-pass leb128 / record decoder
module clsd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_byte_value,
    input  logic            i_start_record,
    input  logic            i_room,
    output clsd_pkg::t_push o_push
);
    import clsd_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // parser state
    logic [2:0] r_section,  n_section;
    t_word      r_acc,      n_acc;
    logic [2:0] r_bpos,     n_bpos;
    logic [1:0] r_hslot,    n_hslot;
    logic [1:0] r_eslot,    n_eslot;
    t_word      r_left,     n_left;
    t_word      r_counts [4];
    t_word      n_counts [4];
    t_word      r_running,  n_running;
    t_word      r_pending,  n_pending;

    // state seen by the current byte, after a forced restart
    logic [2:0] e_section;
    t_word      e_acc;
    logic [2:0] e_bpos;
    logic [1:0] e_hslot;
    logic [1:0] e_eslot;
    t_word      e_left;
    t_word      e_counts [4];
    t_word      e_running;

    logic       w_fire;
    t_word      w_shifted;
    t_word      w_acc_new;
    logic       w_do_adv;
    logic [2:0] w_adv_from;
    logic       w_per3;
    t_push      w_push;

    assign w_fire  = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign o_push  = w_push;

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_in_byte  <= i_byte_value;
            r_in_start <= i_start_record;
        end
    end

    // restart view of the state
    always_comb begin
        e_section = r_in_start ? SEC_HEADER : r_section;
        e_acc     = r_in_start ? '0 : r_acc;
        e_bpos    = r_in_start ? '0 : r_bpos;
        e_hslot   = r_in_start ? '0 : r_hslot;
        e_eslot   = r_in_start ? '0 : r_eslot;
        e_left    = r_in_start ? '0 : r_left;
        e_running = r_in_start ? '0 : r_running;
        for (int k = 0; k < 4; k++) begin
            e_counts[k] = r_in_start ? '0 : r_counts[k];
        end
    end

    // seven-bit group placed at its byte position
    always_comb begin
        case (e_bpos)
            3'd0:    w_shifted = {25'b0, r_in_byte[6:0]};
            3'd1:    w_shifted = {18'b0, r_in_byte[6:0], 7'b0};
            3'd2:    w_shifted = {11'b0, r_in_byte[6:0], 14'b0};
            3'd3:    w_shifted = {4'b0, r_in_byte[6:0], 21'b0};
            3'd4:    w_shifted = {r_in_byte[3:0], 28'b0};
            default: w_shifted = '0;
        endcase
        w_acc_new = e_acc | w_shifted;
    end

    // number decode, section walk and result build
    always_comb begin
        n_section  = r_section;
        n_acc      = r_acc;
        n_bpos     = r_bpos;
        n_hslot    = r_hslot;
        n_eslot    = r_eslot;
        n_left     = r_left;
        n_running  = r_running;
        n_pending  = r_pending;
        for (int k = 0; k < 4; k++) begin
            n_counts[k] = r_counts[k];
        end
        w_push     = '0;
        w_do_adv   = 1'b0;
        w_adv_from = SEC_STATIC;
        w_per3     = (e_section == SEC_DIRECT) || (e_section == SEC_VIRTUAL);

        if (w_fire) begin
            n_section = e_section;
            n_hslot   = e_hslot;
            n_eslot   = e_eslot;
            n_left    = e_left;
            n_running = e_running;
            n_pending = r_in_start ? '0 : r_pending;
            for (int k = 0; k < 4; k++) begin
                n_counts[k] = e_counts[k];
            end

            if (((r_in_byte & LEB_CONT_MASK) != 8'h00) && (e_bpos < LEB_LAST_POS)) begin
                // number continues
                n_acc  = w_acc_new;
                n_bpos = e_bpos + 3'd1;
            end else begin
                n_acc  = '0;
                n_bpos = '0;
                if ((e_section == SEC_HEADER) || (e_section > SEC_VIRTUAL)) begin
                    // header count
                    n_counts[e_hslot] = w_acc_new;
                    if (e_hslot == 2'd3) begin
                        n_hslot    = '0;
                        w_do_adv   = 1'b1;
                        w_adv_from = SEC_STATIC;
                    end else begin
                        n_hslot = e_hslot + 2'd1;
                    end
                end else begin
                    // entry number
                    if (e_section == SEC_INSTANCE) begin
                        if (e_eslot == 2'd0) begin
                            n_pending = e_running + w_acc_new;
                            n_running = e_running + w_acc_new;
                        end else begin
                            w_push.field_valid        = 1'b1;
                            w_push.field.kind         = KIND_FIELD;
                            w_push.field.field_index  = r_in_start ? '0 : r_pending;
                            w_push.field.access_flags = w_acc_new;
                            w_push.field.last_field   = (e_left == 32'd1);
                        end
                    end
                    if (e_eslot >= (w_per3 ? 2'd2 : 2'd1)) begin
                        n_eslot = '0;
                        n_left  = e_left - 32'd1;
                        if (n_left == '0) begin
                            w_do_adv   = 1'b1;
                            w_adv_from = e_section + 3'd1;
                        end
                    end else begin
                        n_eslot = e_eslot + 2'd1;
                    end
                end

                // enter next nonempty section or close the record
                if (w_do_adv) begin
                    if ((w_adv_from <= SEC_STATIC) && (n_counts[0] != '0)) begin
                        n_section = SEC_STATIC;
                        n_left    = n_counts[0];
                        n_eslot   = '0;
                    end else if ((w_adv_from <= SEC_INSTANCE) && (n_counts[1] != '0)) begin
                        n_section = SEC_INSTANCE;
                        n_left    = n_counts[1];
                        n_eslot   = '0;
                    end else if ((w_adv_from <= SEC_DIRECT) && (n_counts[2] != '0)) begin
                        n_section = SEC_DIRECT;
                        n_left    = n_counts[2];
                        n_eslot   = '0;
                    end else if ((w_adv_from <= SEC_VIRTUAL) && (n_counts[3] != '0)) begin
                        n_section = SEC_VIRTUAL;
                        n_left    = n_counts[3];
                        n_eslot   = '0;
                    end else begin
                        w_push.sum_valid              = 1'b1;
                        w_push.summary.kind           = KIND_SUMMARY;
                        w_push.summary.static_count   = n_counts[0];
                        w_push.summary.instance_count = n_counts[1];
                        w_push.summary.direct_count   = n_counts[2];
                        w_push.summary.virtual_count  = n_counts[3];
                        n_section = SEC_HEADER;
                        n_hslot   = '0;
                        n_eslot   = '0;
                        n_left    = '0;
                        n_running = '0;
                        n_pending = '0;
                        for (int k = 0; k < 4; k++) begin
                            n_counts[k] = '0;
                        end
                    end
                end
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section <= SEC_HEADER;
            r_acc     <= '0;
            r_bpos    <= '0;
            r_hslot   <= '0;
            r_eslot   <= '0;
            r_left    <= '0;
            r_running <= '0;
            r_pending <= '0;
            for (int k = 0; k < 4; k++) begin
                r_counts[k] <= '0;
            end
        end else begin
            r_section <= n_section;
            r_acc     <= n_acc;
            r_bpos    <= n_bpos;
            r_hslot   <= n_hslot;
            r_eslot   <= n_eslot;
            r_left    <= n_left;
            r_running <= n_running;
            r_pending <= n_pending;
            for (int k = 0; k < 4; k++) begin
                r_counts[k] <= n_counts[k];
            end
        end
    end

    // a field result only comes from the instance section without restart
    a_field_in_instance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.field_valid |-> (!r_in_start && r_section == SEC_INSTANCE))
        else $error("field result outside instance section");

    // a summary leaves the parser at the start of a new record
    a_summary_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.sum_valid |=> (r_section == SEC_HEADER && r_hslot == 2'd0
                              && r_running == '0))
        else $error("record not restarted after summary");

    // byte position stays within five bytes
    a_bpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bpos <= LEB_LAST_POS)
        else $error("byte position out of range");

endmodule

/* rtl/core/clsd_out_fifo.sv */
// four-entry result queue taking up to two results per cycle
module clsd_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clsd_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_stall,
    output clsd_pkg::t_result o_result
);
    import clsd_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr;
    logic [FIFO_AW-1:0]   r_rd, n_rd;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 w_pop;
    logic                 w_any;
    logic [FIFO_CW-1:0]   w_npush;
    t_result              w_first;

    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_result = r_mem[r_rd];
    assign w_pop    = o_valid && !i_stall;
    assign w_any    = i_push.field_valid || i_push.sum_valid;
    assign w_first  = i_push.field_valid ? i_push.field : i_push.summary;

    // pointer and count update
    always_comb begin
        w_npush = FIFO_CW'(i_push.field_valid) + FIFO_CW'(i_push.sum_valid);
        n_wr    = r_wr + FIFO_AW'(w_npush);
        n_rd    = r_rd + FIFO_AW'(w_pop);
        n_count = r_count + w_npush - FIFO_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_any) begin
            r_mem[r_wr] <= w_first;
        end
        if (i_push.field_valid && i_push.sum_valid) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_push.summary;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue over depth");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_any |-> r_count <= FIFO_CW'(FIFO_DEPTH - 2))
        else $error("push without room for two results");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("empty queue with pointers apart");

endmodule

/* rtl/core/class_data_uleb128_parser_core.sv */
// top level of the class-data record parser
//
//  channel  direction  handshake          beat payload
//  input    in         i_valid / o_stall  i_byte_value, i_start_record
//  output   out        o_valid / i_stall  o_kind, o_field_index, o_access_flags,
//                                         o_last_field, o_*_count
//
// one byte beat per cycle is taken while o_stall is low; each byte is decoded in
// one pass between the input register and the result queue, so its result beat is
// offered once the byte has left the input register and been written to the queue.
// a byte that closes the final instance field and the record gives two beats,
// which leave the four-entry queue at one per cycle while i_stall is low.
// o_stall rises while a byte is held and the queue has fewer than two free entries.
// synchronous reset clears the record state to the start of a record.
module class_data_uleb128_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_start_record,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [31:0] o_field_index,
    output logic [31:0] o_access_flags,
    output logic        o_last_field,
    output logic [31:0] o_static_count,
    output logic [31:0] o_instance_count,
    output logic [31:0] o_direct_count,
    output logic [31:0] o_virtual_count
);
    import clsd_pkg::*;

    t_push   w_push;
    logic    w_room;
    t_result w_result;

    // decoder
    clsd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_value   (i_byte_value),
        .i_start_record (i_start_record),
        .i_room         (w_room),
        .o_push         (w_push)
    );

    // result queue
    clsd_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_room   (w_room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (w_result)
    );

    // output fields
    assign o_kind           = w_result.kind;
    assign o_field_index    = w_result.field_index;
    assign o_access_flags   = w_result.access_flags;
    assign o_last_field     = w_result.last_field;
    assign o_static_count   = w_result.static_count;
    assign o_instance_count = w_result.instance_count;
    assign o_direct_count   = w_result.direct_count;
    assign o_virtual_count  = w_result.virtual_count;

endmodule
